// ===== rtl/aar_pkg.sv =====
// shared constants and types for the axis-angle rotation matrix block
// no dependencies
package aar_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_BITS     = FRAC_BITS + 2;

    localparam int ROOT_STAGES  = 32;
    localparam int DIV_STAGES   = 31;
    localparam int HORNER_STEPS = 6;
    localparam int SIN_STEPS    = 5;

    localparam int SIN_DIV [SIN_STEPS]    = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

    localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [63:0] HALF30  = 64'h2000_0000;
    localparam logic [63:0] ONE30   = 64'h4000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic [2:0][31:0] t_trip;
    typedef logic signed [OUT_BITS-1:0] t_entry;

endpackage

// ===== rtl/axis_angle_rotation_matrix.sv =====
// axis-angle to 3x3 rotation matrix, fully pipelined
// depends on aar_pkg
//
// Takes an axis (three signed components, any nonzero length) and a binary angle and
// returns the nine Q1.14 entries of the rotation matrix, column by column, plus a flag
// for a zero axis, which gives the identity. One transfer is taken every cycle unless the
// output stalls; the pipeline depth is set mostly by the 32-stage square root and the
// 31-stage restoring dividers of the axis normalization. A stall on the output holds the
// whole pipeline.
module axis_angle_rotation_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [aar_pkg::COORD_BITS-1:0] i_axis_x,
    input  logic signed [aar_pkg::COORD_BITS-1:0] i_axis_y,
    input  logic signed [aar_pkg::COORD_BITS-1:0] i_axis_z,
    input  logic        [aar_pkg::ANGLE_BITS-1:0] i_turn_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col0_row0,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col0_row1,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col0_row2,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col1_row0,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col1_row1,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col1_row2,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col2_row0,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col2_row1,
    output logic signed [aar_pkg::OUT_BITS-1:0] o_col2_row2,
    output logic                                o_axis_zero
);
    import aar_pkg::*;

    localparam int DIV_END  = 5 + ROOT_STAGES + DIV_STAGES;
    localparam int SC_END   = 3 + 2 * HORNER_STEPS + 1;
    localparam int SC_DELAY = DIV_END - SC_END;
    localparam int LAT      = DIV_END + 4;
    localparam int FRAC_SH  = 30 - FRAC_BITS;
    localparam logic [35:0] RND     = (36'(1) << FRAC_SH) >> 1;
    localparam logic [35:0] LIM     = 36'(1) << FRAC_BITS;
    localparam t_entry      ENTRY_ONE = OUT_BITS'(1) << FRAC_BITS;
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // front: magnitude, normalizing shift, squares, sum
    logic [2:0][COORD_BITS-1:0] w_axis, n1_mag, r1_mag, r2_mag;
    logic [COORD_BITS-1:0]      n1_max, r1_max;
    logic [2:0]                 r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;
    logic [31:0]                w_mx32;
    logic [4:0]                 n2_lead, n2_sh, r2_sh;
    logic                       r2_zero, r3_zero, r4_zero, r5_zero;
    t_trip                      r3_m, r4_m, r5_m;
    logic [2:0][63:0]           r4_sq;
    logic [63:0]                r5_sum;

    assign w_axis[0] = i_axis_x;
    assign w_axis[1] = i_axis_y;
    assign w_axis[2] = i_axis_z;
    assign w_mx32    = 32'(r1_max);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = w_axis[i][COORD_BITS-1] ? (~w_axis[i] + 1'b1) : w_axis[i];
        end
        n1_max = n1_mag[0];
        if (n1_mag[1] > n1_max) n1_max = n1_mag[1];
        if (n1_mag[2] > n1_max) n1_max = n1_mag[2];
    end

    always_comb begin
        n2_lead = '0;
        for (int b = 0; b < 32; b++) begin
            if (w_mx32[b]) n2_lead = 5'(b);
        end
        n2_sh = (n2_lead >= 5'd30) ? 5'd0 : 5'd30 - n2_lead;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag  <= n1_mag;
            r1_max  <= n1_max;
            r1_neg  <= {w_axis[2][COORD_BITS-1], w_axis[1][COORD_BITS-1],
                        w_axis[0][COORD_BITS-1]};
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_sh   <= n2_sh;
            r2_zero <= (r1_max == '0);
            for (int i = 0; i < 3; i++) begin
                r3_m[i]  <= 32'(r2_mag[i]) << r2_sh;
                r4_sq[i] <= 64'(r3_m[i]) * 64'(r3_m[i]);
            end
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r4_m    <= r3_m;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r5_sum  <= r4_sq[0] + r4_sq[1] + r4_sq[2];
            r5_m    <= r4_m;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    // square root, one result bit per stage
    logic [33:0] r_rt_rem  [ROOT_STAGES];
    logic [31:0] r_rt_root [ROOT_STAGES];
    logic [63:0] r_rt_sum  [ROOT_STAGES];
    t_trip       r_rt_m    [ROOT_STAGES];
    logic [2:0]  r_rt_neg  [ROOT_STAGES];
    logic        r_rt_zero [ROOT_STAGES];

    for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_sum;
        t_trip       w_m;
        logic [2:0]  w_neg;
        logic        w_zero;
        logic [35:0] w_try;
        logic [35:0] w_trial;
        if (i == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_sum  = r5_sum;
            assign w_m    = r5_m;
            assign w_neg  = r5_neg;
            assign w_zero = r5_zero;
        end else begin : g_next
            assign w_rem  = r_rt_rem[i-1];
            assign w_root = r_rt_root[i-1];
            assign w_sum  = r_rt_sum[i-1];
            assign w_m    = r_rt_m[i-1];
            assign w_neg  = r_rt_neg[i-1];
            assign w_zero = r_rt_zero[i-1];
        end
        assign w_try   = {w_rem, w_sum[63-2*i -: 2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (w_try >= w_trial) begin
                    r_rt_rem[i]  <= 34'(w_try - w_trial);
                    r_rt_root[i] <= {w_root[30:0], 1'b1};
                end else begin
                    r_rt_rem[i]  <= w_try[33:0];
                    r_rt_root[i] <= {w_root[30:0], 1'b0};
                end
                r_rt_sum[i]  <= w_sum;
                r_rt_m[i]    <= w_m;
                r_rt_neg[i]  <= w_neg;
                r_rt_zero[i] <= w_zero;
            end
        end
    end

    // three restoring dividers, one quotient bit per stage
    logic [2:0][32:0] r_dv_rem  [DIV_STAGES];
    logic [2:0][30:0] r_dv_quo  [DIV_STAGES];
    logic [31:0]      r_dv_n    [DIV_STAGES];
    logic [2:0]       r_dv_neg  [DIV_STAGES];
    logic             r_dv_zero [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [2:0][32:0] w_rem;
        logic [2:0][30:0] w_quo;
        logic [31:0]      w_n;
        logic [2:0]       w_neg;
        logic             w_zero;
        logic [2:0][33:0] w_try;
        logic [33:0]      w_den;
        if (j == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign w_rem[i] = 33'(r_rt_m[ROOT_STAGES-1][i])
                                + 33'(r_rt_root[ROOT_STAGES-1][31]);
            end
            assign w_quo  = '0;
            assign w_n    = r_rt_root[ROOT_STAGES-1];
            assign w_neg  = r_rt_neg[ROOT_STAGES-1];
            assign w_zero = r_rt_zero[ROOT_STAGES-1];
        end else begin : g_next
            assign w_rem  = r_dv_rem[j-1];
            assign w_quo  = r_dv_quo[j-1];
            assign w_n    = r_dv_n[j-1];
            assign w_neg  = r_dv_neg[j-1];
            assign w_zero = r_dv_zero[j-1];
        end
        assign w_den = {1'b0, w_n, 1'b0};
        for (genvar i = 0; i < 3; i++) begin : g_try
            assign w_try[i] = {w_rem[i], w_n[DIV_STAGES-1-j]};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_try[i] >= w_den) begin
                        r_dv_rem[j][i] <= 33'(w_try[i] - w_den);
                        r_dv_quo[j][i] <= {w_quo[i][29:0], 1'b1};
                    end else begin
                        r_dv_rem[j][i] <= w_try[i][32:0];
                        r_dv_quo[j][i] <= {w_quo[i][29:0], 1'b0};
                    end
                end
                r_dv_n[j]    <= w_n;
                r_dv_neg[j]  <= w_neg;
                r_dv_zero[j] <= w_zero;
            end
        end
    end

    // sine and cosine: range reduction, scaling, horner steps
    logic [31:0] w_theta;
    logic [29:0] w_r;
    logic        w_swap;
    logic [29:0] r1_rr, r2_x, r3_x, r3_x2;
    logic [1:0]  r1_q, r2_q, r3_q;
    logic        r1_sw, r2_sw, r3_sw;

    assign w_theta = 32'(64'(i_turn_angle) << (32 - ANGLE_BITS));
    assign w_r     = w_theta[29:0];
    assign w_swap  = (w_r > 30'h2000_0000);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q  <= w_theta[31:30];
            r1_sw <= w_swap;
            r1_rr <= w_swap ? 30'(Q30_ONE - 31'(w_r)) : w_r;
            r2_q  <= r1_q;
            r2_sw <= r1_sw;
            r2_x  <= 30'((64'(r1_rr) * 64'(PI_Q30) + ONE30) >> 31);
            r3_q  <= r2_q;
            r3_sw <= r2_sw;
            r3_x  <= r2_x;
            r3_x2 <= 30'((64'(r2_x) * 64'(r2_x) + HALF30) >> 30);
        end
    end

    logic [29:0] r_ha_x  [HORNER_STEPS];
    logic [29:0] r_ha_x2 [HORNER_STEPS];
    logic [1:0]  r_ha_q  [HORNER_STEPS];
    logic        r_ha_sw [HORNER_STEPS];
    logic [30:0] r_ha_ps [HORNER_STEPS];
    logic [30:0] r_ha_pc [HORNER_STEPS];
    logic [29:0] r_hb_x  [HORNER_STEPS];
    logic [29:0] r_hb_x2 [HORNER_STEPS];
    logic [1:0]  r_hb_q  [HORNER_STEPS];
    logic        r_hb_sw [HORNER_STEPS];
    logic [30:0] r_hb_ts [HORNER_STEPS];
    logic [30:0] r_hb_tc [HORNER_STEPS];

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        localparam int unsigned CD  = COS_DIV[j];
        localparam int          CSH = 31 + $clog2(CD);
        localparam logic [31:0] CM  = 32'(((64'd1 << CSH) + 64'(CD) - 64'd1) / 64'(CD));
        logic [29:0] w_x;
        logic [29:0] w_x2;
        logic [1:0]  w_q;
        logic        w_sw;
        logic [30:0] w_ts;
        logic [30:0] w_tc;
        if (j == 0) begin : g_first
            assign w_x  = r3_x;
            assign w_x2 = r3_x2;
            assign w_q  = r3_q;
            assign w_sw = r3_sw;
            assign w_ts = Q30_ONE;
            assign w_tc = Q30_ONE;
        end else begin : g_next
            assign w_x  = r_hb_x[j-1];
            assign w_x2 = r_hb_x2[j-1];
            assign w_q  = r_hb_q[j-1];
            assign w_sw = r_hb_sw[j-1];
            assign w_ts = r_hb_ts[j-1];
            assign w_tc = r_hb_tc[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ha_x[j]  <= w_x;
                r_ha_x2[j] <= w_x2;
                r_ha_q[j]  <= w_q;
                r_ha_sw[j] <= w_sw;
                r_ha_pc[j] <= 31'((64'(w_x2) * 64'(w_tc) + HALF30) >> 30);
                r_hb_x[j]  <= r_ha_x[j];
                r_hb_x2[j] <= r_ha_x2[j];
                r_hb_q[j]  <= r_ha_q[j];
                r_hb_sw[j] <= r_ha_sw[j];
                r_hb_tc[j] <= Q30_ONE - 31'((64'(r_ha_pc[j]) * 64'(CM)) >> CSH);
            end
        end

        if (j < SIN_STEPS) begin : g_sin
            localparam int unsigned SD  = SIN_DIV[j];
            localparam int          SSH = 31 + $clog2(SD);
            localparam logic [31:0] SM  = 32'(((64'd1 << SSH) + 64'(SD) - 64'd1) / 64'(SD));
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ha_ps[j] <= 31'((64'(w_x2) * 64'(w_ts) + HALF30) >> 30);
                    r_hb_ts[j] <= Q30_ONE - 31'((64'(r_ha_ps[j]) * 64'(SM)) >> SSH);
                end
            end
        end else if (j == SIN_STEPS) begin : g_sin_last
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ha_ps[j] <= 31'((64'(w_x) * 64'(w_ts) + HALF30) >> 30);
                    r_hb_ts[j] <= r_ha_ps[j];
                end
            end
        end else begin : g_sin_hold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ha_ps[j] <= w_ts;
                    r_hb_ts[j] <= r_ha_ps[j];
                end
            end
        end
    end

    // quadrant fold-out, then delay to meet the normalized axis
    logic [30:0]        w_s0, w_c0;
    logic signed [31:0] n16_s, n16_c, r16_s, r16_c;
    logic [31:0]        r16_k;
    logic signed [31:0] r_sd [SC_DELAY];
    logic signed [31:0] r_cd [SC_DELAY];
    logic [31:0]        r_kd [SC_DELAY];

    assign w_s0 = r_hb_sw[HORNER_STEPS-1] ? r_hb_tc[HORNER_STEPS-1] : r_hb_ts[HORNER_STEPS-1];
    assign w_c0 = r_hb_sw[HORNER_STEPS-1] ? r_hb_ts[HORNER_STEPS-1] : r_hb_tc[HORNER_STEPS-1];

    always_comb begin
        unique case (r_hb_q[HORNER_STEPS-1])
            QUAD_0: begin
                n16_s = 32'(w_s0);
                n16_c = 32'(w_c0);
            end
            QUAD_1: begin
                n16_s = 32'(w_c0);
                n16_c = -32'(w_s0);
            end
            QUAD_2: begin
                n16_s = -32'(w_s0);
                n16_c = -32'(w_c0);
            end
            default: begin
                n16_s = -32'(w_c0);
                n16_c = 32'(w_s0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r16_s   <= n16_s;
            r16_c   <= n16_c;
            r16_k   <= 32'(33'(ONE30) - 33'(n16_c));
            r_sd[0] <= r16_s;
            r_cd[0] <= r16_c;
            r_kd[0] <= r16_k;
            for (int i = 1; i < SC_DELAY; i++) begin
                r_sd[i] <= r_sd[i-1];
                r_cd[i] <= r_cd[i-1];
                r_kd[i] <= r_kd[i-1];
            end
        end
    end

    // matrix products, sums, rounding, clamping
    logic [2:0][30:0]   w_u;
    logic [2:0]         w_un;
    logic signed [31:0] w_s;
    logic [30:0]        w_smag;
    logic [30:0]        r69_uu [6];
    logic [5:0]         r69_uun;
    logic [30:0]        r69_su [3];
    logic [2:0]         r69_sun;
    logic [31:0]        r69_k;
    logic signed [31:0] r69_c, r70_c;
    logic               r69_zero, r70_zero, r71_zero;
    logic signed [33:0] r70_kv [6];
    logic signed [32:0] r70_sv [3];
    logic signed [35:0] r71_e  [9];
    logic [32:0]        w_kp   [6];
    logic [35:0]        w_mag  [9];
    logic [35:0]        w_rm   [9];
    t_entry             n_out  [9];
    t_entry             r_out  [9];
    logic               r_zero;

    assign w_u    = r_dv_quo[DIV_STAGES-1];
    assign w_un   = r_dv_neg[DIV_STAGES-1];
    assign w_s    = r_sd[SC_DELAY-1];
    assign w_smag = w_s[31] ? 31'(-w_s) : 31'(w_s);

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            w_kp[p] = 33'((64'(r69_uu[p]) * 64'(r69_k) + HALF30) >> 30);
        end
        for (int i = 0; i < 9; i++) begin
            w_mag[i] = r71_e[i][35] ? 36'(-r71_e[i]) : 36'(r71_e[i]);
            w_rm[i]  = (w_mag[i] + RND) >> FRAC_SH;
            if (w_rm[i] > LIM) w_rm[i] = LIM;
            n_out[i] = r71_e[i][35] ? OUT_BITS'(-w_rm[i]) : OUT_BITS'(w_rm[i]);
            if (r71_zero) begin
                n_out[i] = (i % 4 == 0) ? ENTRY_ONE : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 6; p++) begin
                r69_uu[p]  <= 31'((64'(w_u[PA[p]]) * 64'(w_u[PB[p]]) + HALF30) >> 30);
                r69_uun[p] <= w_un[PA[p]] ^ w_un[PB[p]];
                r70_kv[p]  <= r69_uun[p] ? -34'(w_kp[p]) : 34'(w_kp[p]);
            end
            for (int i = 0; i < 3; i++) begin
                r69_su[i]  <= 31'((64'(w_smag) * 64'(w_u[i]) + HALF30) >> 30);
                r69_sun[i] <= w_s[31] ^ w_un[i];
                r70_sv[i]  <= r69_sun[i] ? -33'(r69_su[i]) : 33'(r69_su[i]);
            end
            r69_k    <= r_kd[SC_DELAY-1];
            r69_c    <= r_cd[SC_DELAY-1];
            r69_zero <= r_dv_zero[DIV_STAGES-1];
            r70_c    <= r69_c;
            r70_zero <= r69_zero;
            r71_e[0] <= 36'(r70_kv[0]) + 36'(r70_c);
            r71_e[1] <= 36'(r70_kv[3]) + 36'(r70_sv[2]);
            r71_e[2] <= 36'(r70_kv[4]) - 36'(r70_sv[1]);
            r71_e[3] <= 36'(r70_kv[3]) - 36'(r70_sv[2]);
            r71_e[4] <= 36'(r70_kv[1]) + 36'(r70_c);
            r71_e[5] <= 36'(r70_kv[5]) + 36'(r70_sv[0]);
            r71_e[6] <= 36'(r70_kv[4]) + 36'(r70_sv[1]);
            r71_e[7] <= 36'(r70_kv[5]) - 36'(r70_sv[0]);
            r71_e[8] <= 36'(r70_kv[2]) + 36'(r70_c);
            r71_zero <= r70_zero;
            r_out    <= n_out;
            r_zero   <= r71_zero;
        end
    end

    assign o_col0_row0 = r_out[0];
    assign o_col0_row1 = r_out[1];
    assign o_col0_row2 = r_out[2];
    assign o_col1_row0 = r_out[3];
    assign o_col1_row1 = r_out[4];
    assign o_col1_row2 = r_out[5];
    assign o_col2_row0 = r_out[6];
    assign o_col2_row1 = r_out[7];
    assign o_col2_row2 = r_out[8];
    assign o_axis_zero = r_zero;

`ifndef SYNTHESIS
    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_axis_zero |-> o_col0_row0 == ENTRY_ONE && o_col1_row1 == ENTRY_ONE
            && o_col2_row2 == ENTRY_ONE && o_col0_row1 == '0 && o_col1_row0 == '0
            && o_col2_row1 == '0)
        else $error("zero axis did not give the identity");

    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_col0_row0 <= ENTRY_ONE && o_col0_row0 >= -ENTRY_ONE
            && o_col1_row1 <= ENTRY_ONE && o_col1_row1 >= -ENTRY_ONE
            && o_col2_row2 <= ENTRY_ONE && o_col2_row2 >= -ENTRY_ONE)
        else $error("diagonal entry outside clamp range");
`endif

endmodule

// ===== test/tb.sv =====
// testbench for axis_angle_rotation_matrix: random and directed axis/angle transfers
// checked against a fixed-point rotation matrix predictor; depends on aar_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import aar_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az;
        logic [15:0]        ang;
    } t_axis_item;

    typedef struct {
        logic [15:0] e [9];
        logic        zero;
    } t_matrix;

    logic i_clk, i_rst_n;
    logic i_valid, i_stall;
    logic o_stall, o_valid, o_axis_zero;
    logic signed [15:0] i_axis_x, i_axis_y, i_axis_z;
    logic [15:0] i_turn_angle;
    t_entry o_e [9];

    t_axis_item pending_q [$];
    t_matrix    matrix_q [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit hold_rx = 0;
    bit sender_pause = 0;
    int tx_gap = 0, rx_gap = 0;

    axis_angle_rotation_matrix u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_axis_x(i_axis_x), .i_axis_y(i_axis_y), .i_axis_z(i_axis_z),
        .i_turn_angle(i_turn_angle), .o_valid(o_valid), .i_stall(i_stall),
        .o_col0_row0(o_e[0]), .o_col0_row1(o_e[1]), .o_col0_row2(o_e[2]),
        .o_col1_row0(o_e[3]), .o_col1_row1(o_e[4]), .o_col1_row2(o_e[5]),
        .o_col2_row0(o_e[6]), .o_col2_row1(o_e[7]), .o_col2_row2(o_e[8]),
        .o_axis_zero(o_axis_zero)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        longint unsigned p;
        p = (mag(a) * mag(b) + HALF30) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [15:0] to_entry(longint v);
        longint unsigned m;
        longint r;
        m = (mag(v) + (64'd1 << 15)) >> 16;
        if (m > (64'd1 << FRAC_BITS)) m = 64'd1 << FRAC_BITS;
        r = v < 0 ? -longint'(m) : longint'(m);
        return r[15:0];
    endfunction

    // first-octant sine and cosine of r (30-bit quarter-turn fraction)
    task automatic octant_sincos(longint unsigned r, output longint unsigned s,
                                 output longint unsigned c);
        longint unsigned x, x2, t;
        x = (r * 64'hC90FDAA2 + ONE30) >> 31;
        x2 = (x * x + HALF30) >> 30;
        t = ONE30;
        for (int i = 0; i < SIN_STEPS; i++)
            t = ONE30 - (((x2 * t + HALF30) >> 30) / SIN_DIV[i]);
        s = (x * t + HALF30) >> 30;
        t = ONE30;
        for (int i = 0; i < HORNER_STEPS; i++)
            t = ONE30 - (((x2 * t + HALF30) >> 30) / COS_DIV[i]);
        c = t;
    endtask

    task automatic predict_matrix(t_axis_item it, output t_matrix m);
        longint a [3], u [3];
        longint unsigned mg [3], mx, sum, n, theta, r, s0, c0, v;
        longint s, c, k, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        logic [1:0] quad;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        for (int i = 0; i < 3; i++) mg[i] = mag(a[i]);
        mx = mg[0];
        if (mg[1] > mx) mx = mg[1];
        if (mg[2] > mx) mx = mg[2];
        if (mx == 0) begin
            for (int i = 0; i < 9; i++) m.e[i] = (i % 4 == 0) ? 16'sd16384 : 16'd0;
            m.zero = 1;
            return;
        end
        while (mx < ONE30) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mg[i] <<= 1;
        end
        sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            v = (mg[i] * ONE30 * 2 + n) / (2 * n);
            u[i] = a[i] < 0 ? -longint'(v) : longint'(v);
        end
        theta = longint'(it.ang) << 16;
        quad = theta[31:30];
        r = theta & (ONE30 - 1);
        if (r <= HALF30) octant_sincos(r, s0, c0);
        else octant_sincos(ONE30 - r, c0, s0);
        case (quad)
            QUAD_0: begin s = s0; c = c0; end
            QUAD_1: begin s = c0; c = -longint'(s0); end
            QUAD_2: begin s = -longint'(s0); c = -longint'(c0); end
            default: begin s = -longint'(c0); c = s0; end
        endcase
        k = longint'(ONE30) - c;
        xx = q30_mul(q30_mul(u[0], u[0]), k);
        yy = q30_mul(q30_mul(u[1], u[1]), k);
        zz = q30_mul(q30_mul(u[2], u[2]), k);
        xy = q30_mul(q30_mul(u[0], u[1]), k);
        xz = q30_mul(q30_mul(u[0], u[2]), k);
        yz = q30_mul(q30_mul(u[1], u[2]), k);
        sx = q30_mul(s, u[0]);
        sy = q30_mul(s, u[1]);
        sz = q30_mul(s, u[2]);
        m.e[0] = to_entry(xx + c);
        m.e[1] = to_entry(xy + sz);
        m.e[2] = to_entry(xz - sy);
        m.e[3] = to_entry(xy - sz);
        m.e[4] = to_entry(yy + c);
        m.e[5] = to_entry(yz + sx);
        m.e[6] = to_entry(xz + sy);
        m.e[7] = to_entry(yz - sx);
        m.e[8] = to_entry(zz + c);
        m.zero = 0;
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic add_item(int x, int y, int z, int ang);
        t_axis_item it;
        it.ax = 16'(x); it.ay = 16'(y); it.az = 16'(z); it.ang = 16'(ang);
        pending_q.push_back(it);
    endtask

    function automatic int rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 0;
        if (p == 1) return $urandom_range(0, 7) - 4;
        if (p == 2) return $urandom_range(0, 1) ? -32768 : 32767;
        return $urandom_range(0, 65535);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_matrix want;
        if (!i_rst_n) begin
            i_valid <= 0;
            i_axis_x <= '0;
            i_axis_y <= '0;
            i_axis_z <= '0;
            i_turn_angle <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_matrix(pending_q.pop_front(), want);
                matrix_q.push_back(want);
            end
            if (i_valid && o_stall) begin
                // hold payload
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 0;
            end else if (pending_q.size() > 0 && !sender_pause) begin
                i_valid <= 1;
                i_axis_x <= pending_q[0].ax;
                i_axis_y <= pending_q[0].ay;
                i_axis_z <= pending_q[0].az;
                i_turn_angle <= pending_q[0].ang;
                if (!stim_done) tx_gap <= pick_gap();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_matrix want;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (matrix_q.size() == 0) begin
                    report_mismatch("unexpected result transfer", o_e[0], '0);
                end else begin
                    want = matrix_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (o_e[i] !== want.e[i])
                            report_mismatch($sformatf("entry %0d", i), o_e[i], want.e[i]);
                    if (o_axis_zero !== want.zero)
                        report_mismatch("axis_zero", o_axis_zero, want.zero);
                end
            end
            if (hold_rx) begin
                i_stall <= 1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
                rx_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: zero axis, unit axes, extremes, quadrant boundaries, octant split
        add_item(0, 0, 0, 16'h1234);
        add_item(0, 0, 0, 0);
        add_item(1, 0, 0, 16'h4000);
        add_item(0, 1, 0, 16'h4000);
        add_item(0, 0, 1, 16'h4000);
        add_item(32767, 32767, 32767, 16'h8000);
        add_item(-32768, -32768, -32768, 16'hC000);
        add_item(-32768, 0, 0, 16'hFFFF);
        add_item(0, -32768, 32767, 16'h2000);
        add_item(-1, -1, -1, 16'h2001);
        add_item(5, -3, 7, 16'h1FFF);
        add_item(100, 200, -300, 16'h0001);
        add_item(32767, -32768, 1, 16'h7FFF);
        add_item(0, 0, -1, 16'h8001);
        add_item(3, 4, 0, 16'hE000);
        add_item(-7, 0, 9, 16'h5555);
        add_item(1, 1, 0, 16'hAAAA);
        add_item(0, 32767, 0, 16'h6000);
        for (int i = 0; i < 1530; i++)
            add_item(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 65535));
        // receiver holds off long enough to fill the pipeline
        wait (matrix_q.size() > 20);
        @(posedge i_clk);
        hold_rx <= 1;
        repeat (200) @(posedge i_clk);
        hold_rx <= 0;
        // sender pauses until every expected result has come
        wait (pending_q.size() < 800);
        @(posedge i_clk);
        sender_pause <= 1;
        wait (matrix_q.size() == 0 && !i_valid);
        @(posedge i_clk);
        sender_pause <= 0;
        wait (pending_q.size() == 0 && !i_valid);
        stim_done = 1;
        wait (matrix_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
